// ===== design/mendu_pkg.sv =====
`timescale 1ns / 1ps

package mendu_pkg;

	localparam logic [1:0] KIND_ON     = 2'd0;
	localparam logic [1:0] KIND_OFF    = 2'd1;
	localparam logic [1:0] KIND_DAMPER = 2'd2;

	localparam logic REC_NOTE   = 1'b0;
	localparam logic REC_DAMPER = 1'b1;

	localparam logic ST_OK    = 1'b0;
	localparam logic ST_ORPHAN = 1'b1;

	localparam logic [6:0] DAMPER_UP   = 7'd0;
	localparam logic [6:0] DAMPER_DOWN = 7'd1;

	localparam int IDX_MAX_W = 8;

	typedef struct packed {
		logic [31:0] start;
		logic [6:0]  vol;
	} tbl_entry_t;

	typedef struct packed {
		logic                 wr;
		logic                 rd;
		logic                 clr;
		logic [IDX_MAX_W-1:0] idx;
		tbl_entry_t           wdata;
	} tbl_req_t;

endpackage

// ===== design/mendu_table.sv =====
`timescale 1ns / 1ps

module mendu_table #(
	parameter int PITCH_COUNT = 128
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mendu_pkg::tbl_req_t    req,
	output logic                   hit,
	output mendu_pkg::tbl_entry_t  rd_entry
);
	import mendu_pkg::*;

	localparam int IDX_W = (PITCH_COUNT > 1) ? $clog2(PITCH_COUNT) : 1;

	logic [IDX_W-1:0]       idx;
	logic [PITCH_COUNT-1:0] vld_q;
	tbl_entry_t             mem [PITCH_COUNT];

	assign idx = req.idx[IDX_W-1:0];
	assign hit = vld_q[idx];

	// valid bits live in flops so reset clears the whole table at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.wr) begin
			vld_q[idx] <= 1'b1;
		end else if (req.clr) begin
			vld_q[idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[idx] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd) begin
			rd_entry <= mem[idx];
		end
	end

endmodule

// ===== design/midi_event_to_note_duration_unit.sv =====
`timescale 1ns / 1ps

// Pairs note on / note off and damper down / up events into duration records.
// One event is taken every cycle while in_stall is low; a record goes through
// stage one and the output register after its closing event, and an output
// stall backs up through one pipeline stage to the input. Note starts and
// volumes sit in a single-port table of PITCH_COUNT entries with a registered
// read: a note on writes its entry, a note off reads it, so each event uses
// the port once. Per-pitch valid bits are flops cleared by reset, so no
// clearing pass is needed. Time is counted in ticks and wraps at 2^32.
module midi_event_to_note_duration_unit #(
	parameter int PITCH_COUNT = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [27:0] delta_ticks,
	input  logic [6:0]  value_one,
	input  logic [6:0]  velocity,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        record_kind,
	output logic [31:0] start_ticks,
	output logic [31:0] stop_ticks,
	output logic [6:0]  pitch,
	output logic [6:0]  volume,
	output logic        status
);
	import mendu_pkg::*;

	logic        acc;
	logic        advance;
	logic        in_range;
	logic        tbl_hit;
	logic [31:0] t_next;
	logic        adv_time;
	logic        res_gen;
	logic        dmp_set;
	logic        dmp_clr;
	tbl_req_t    tbl_req;
	tbl_entry_t  rd_entry;

	logic [31:0] now_q;
	logic [31:0] dmp_start_q;
	logic        dmp_pend_q;

	logic        res_kind;
	logic        res_hit;
	logic [31:0] res_start;
	logic [6:0]  res_pitch;
	logic        res_status;

	logic        valid_s1;
	logic        kind_s1;
	logic        hit_s1;
	logic [31:0] start_s1;
	logic [31:0] stop_s1;
	logic [6:0]  pitch_s1;
	logic        status_s1;

	logic        out_valid_q;
	logic        kind_q;
	logic [31:0] start_q;
	logic [31:0] stop_q;
	logic [6:0]  pitch_q;
	logic [6:0]  volume_q;
	logic        status_q;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign acc      = in_valid && !in_stall;

	assign in_range = {2'b00, value_one} < 9'(PITCH_COUNT);
	assign t_next   = now_q + {4'b0000, delta_ticks};

	always_comb begin
		adv_time   = 1'b0;
		res_gen    = 1'b0;
		dmp_set    = 1'b0;
		dmp_clr    = 1'b0;
		res_kind   = REC_NOTE;
		res_hit    = 1'b0;
		res_start  = '0;
		res_pitch  = value_one;
		res_status = ST_OK;
		tbl_req       = '0;
		tbl_req.idx   = {1'b0, value_one};
		tbl_req.wdata = '{start: t_next, vol: velocity};
		unique case (req_type)
			KIND_ON: begin
				adv_time   = 1'b1;
				tbl_req.wr = in_range;
			end
			KIND_OFF: begin
				adv_time    = 1'b1;
				res_gen     = 1'b1;
				res_hit     = in_range && tbl_hit;
				res_status  = res_hit ? ST_OK : ST_ORPHAN;
				tbl_req.rd  = res_hit;
				tbl_req.clr = res_hit;
			end
			KIND_DAMPER: begin
				res_kind  = REC_DAMPER;
				res_pitch = '0;
				if (value_one == DAMPER_DOWN) begin
					adv_time = 1'b1;
					dmp_set  = 1'b1;
				end else if (value_one == DAMPER_UP) begin
					adv_time   = 1'b1;
					res_gen    = 1'b1;
					dmp_clr    = 1'b1;
					res_start  = dmp_pend_q ? dmp_start_q : '0;
					res_status = dmp_pend_q ? ST_OK : ST_ORPHAN;
				end
			end
			default: begin
			end
		endcase
		// table and flags only move on an accepted request
		if (!acc) begin
			adv_time    = 1'b0;
			res_gen     = 1'b0;
			dmp_set     = 1'b0;
			dmp_clr     = 1'b0;
			tbl_req.wr  = 1'b0;
			tbl_req.rd  = 1'b0;
			tbl_req.clr = 1'b0;
		end
	end

	mendu_table #(
		.PITCH_COUNT(PITCH_COUNT)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (tbl_req),
		.hit      (tbl_hit),
		.rd_entry (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			dmp_start_q <= '0;
			dmp_pend_q  <= 1'b0;
		end else begin
			if (adv_time) begin
				now_q <= t_next;
			end
			if (dmp_set) begin
				dmp_start_q <= t_next;
				dmp_pend_q  <= 1'b1;
			end else if (dmp_clr) begin
				dmp_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= res_gen;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_gen) begin
			kind_s1   <= res_kind;
			hit_s1    <= res_hit;
			start_s1  <= res_start;
			stop_s1   <= t_next;
			pitch_s1  <= res_pitch;
			status_s1 <= res_status;
		end
	end

	// table read data is held until the next accepted read, so it is
	// still valid while the record waits in stage one
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			kind_q   <= kind_s1;
			start_q  <= hit_s1 ? rd_entry.start : start_s1;
			stop_q   <= stop_s1;
			pitch_q  <= pitch_s1;
			volume_q <= hit_s1 ? rd_entry.vol : 7'd0;
			status_q <= status_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign record_kind = kind_q;
	assign start_ticks = start_q;
	assign stop_ticks  = stop_q;
	assign pitch       = pitch_q;
	assign volume      = volume_q;
	assign status      = status_q;

endmodule

// ===== design/mendu_checker.sv =====
`timescale 1ns / 1ps

module mendu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  req_type,
	input logic [27:0] delta_ticks,
	input logic [6:0]  value_one,
	input logic [6:0]  velocity,
	input logic        out_valid,
	input logic        out_stall,
	input logic        record_kind,
	input logic [31:0] start_ticks,
	input logic [31:0] stop_ticks,
	input logic [6:0]  pitch,
	input logic [6:0]  volume,
	input logic        status
);
	import mendu_pkg::*;

	// a stalled request keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(start_ticks) &&
		$stable(stop_ticks) && $stable(pitch) && $stable(volume) &&
		$stable(status) && $stable(record_kind))
		else $error("output request changed while stalled");

	// input only backs up behind a full, stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// an orphan record carries no start time or volume
	a_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ORPHAN |-> start_ticks == 32'd0 && volume == 7'd0)
		else $error("orphan record with start or volume");

	// damper records carry no pitch or volume
	a_damper: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == REC_DAMPER |-> pitch == 7'd0 && volume == 7'd0)
		else $error("damper record with pitch or volume");

	// a note off accepted into an empty output shows up after stage one and the output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && req_type == KIND_OFF && !out_valid |=> ##1 out_valid)
		else $error("note off record did not appear");

endmodule

bind midi_event_to_note_duration_unit mendu_checker u_mendu_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import mendu_pkg::*;

	localparam int PITCHES = 128;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [27:0] DELTA_MAX = 28'hFFFFFFF;
	localparam int HOLD_CYCLES = 80;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 20;

	typedef struct {
		logic        rec;
		logic [31:0] t_start;
		logic [31:0] t_stop;
		logic [6:0]  key;
		logic [6:0]  vol;
		logic        st;
	} duration_rec_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [27:0] delta_ticks;
	logic [6:0]  value_one;
	logic [6:0]  velocity;
	logic        out_valid;
	logic        out_stall;
	logic        record_kind;
	logic [31:0] start_ticks;
	logic [31:0] stop_ticks;
	logic [6:0]  pitch;
	logic [6:0]  volume;
	logic        status;

	// predictor state
	logic [31:0] clock_now;
	logic [31:0] note_start [PITCHES];
	logic [6:0]  note_vol [PITCHES];
	bit          note_open [PITCHES];
	logic [31:0] pedal_start;
	bit          pedal_open;

	duration_rec_t due_records[$];
	int fail_count;
	int cycle_count;
	int sender_idle_pct;
	int receiver_stall_pct;
	bit hold_request;
	bit hold_done;

	midi_event_to_note_duration_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.delta_ticks(delta_ticks),
		.value_one(value_one),
		.velocity(velocity),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.record_kind(record_kind),
		.start_ticks(start_ticks),
		.stop_ticks(stop_ticks),
		.pitch(pitch),
		.volume(volume),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("midi_event_to_note_duration_unit verification failed");
			$finish;
		end
	end

	// skips ignored events; otherwise advances time and records a start or pairs the event with its pending start
	function automatic void pair_event(input logic [1:0] kind, input logic [27:0] delta,
		input logic [6:0] key, input logic [6:0] vel);
		duration_rec_t r;
		if (kind == KIND_DAMPER && key > DAMPER_DOWN)
			return;
		if (kind != KIND_ON && kind != KIND_OFF && kind != KIND_DAMPER)
			return;
		clock_now = clock_now + {4'd0, delta};
		r = '{REC_NOTE, 32'd0, clock_now, key, 7'd0, ST_ORPHAN};
		case (kind)
			KIND_ON: begin
				if (key < PITCHES) begin
					note_start[key] = clock_now;
					note_vol[key] = vel;
					note_open[key] = 1'b1;
				end
				return;
			end
			KIND_OFF: begin
				if (key < PITCHES && note_open[key]) begin
					r.t_start = note_start[key];
					r.vol = note_vol[key];
					r.st = ST_OK;
					note_open[key] = 1'b0;
				end
			end
			default: begin
				if (key == DAMPER_DOWN) begin
					pedal_start = clock_now;
					pedal_open = 1'b1;
					return;
				end
				r.rec = REC_DAMPER;
				r.key = 7'd0;
				if (pedal_open) begin
					r.t_start = pedal_start;
					r.st = ST_OK;
					pedal_open = 1'b0;
				end
			end
		endcase
		due_records.insert(due_records.size(), r);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		duration_rec_t r;
		if (arst_n && out_valid && !out_stall) begin
			if (due_records.size() == 0) begin
				$error("record with none expected: kind %0d start %0d stop %0d",
					record_kind, start_ticks, stop_ticks);
				fail_count++;
			end else begin
				r = due_records.pop_front();
				check_field("record_kind", r.rec, record_kind);
				check_field("start_ticks", r.t_start, start_ticks);
				check_field("stop_ticks", r.t_stop, stop_ticks);
				check_field("pitch", r.key, pitch);
				check_field("volume", r.vol, volume);
				check_field("status", r.st, status);
			end
		end
	end

	// receiver: random stalls, plus one long hold on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			out_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	task automatic offer_event(input logic [1:0] kind, input logic [27:0] delta,
		input logic [6:0] key, input logic [6:0] vel);
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= kind;
		delta_ticks <= delta;
		value_one <= key;
		velocity <= vel;
		do @(posedge clk); while (in_stall);
		pair_event(kind, delta, key, vel);
		if ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			while ($urandom_range(99) < sender_idle_pct) @(negedge clk);
		end
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_for_records();
		while (due_records.size() != 0) @(posedge clk);
	endtask

	function automatic int find_open_note();
		int base;
		base = $urandom_range(PITCHES - 1);
		for (int i = 0; i < PITCHES; i++)
			if (note_open[(base + i) % PITCHES])
				return (base + i) % PITCHES;
		return -1;
	endfunction

	// mostly matched on/off and pedal pairs, with some orphans and ignored requests
	task automatic make_event(output logic [1:0] kind, output logic [27:0] delta,
		output logic [6:0] key, output logic [6:0] vel);
		int r;
		int k;
		r = $urandom_range(99);
		if (r < 45)
			delta = 28'($urandom_range(15));
		else if (r < 75)
			delta = 28'($urandom);
		else if (r < 90)
			delta = DELTA_MAX;
		else
			delta = '0;
		vel = 7'($urandom);
		key = 7'($urandom);
		r = $urandom_range(99);
		if (r < 38) begin
			kind = KIND_ON;
			if ($urandom_range(1))
				key = 7'($urandom_range(56, 63));
		end else if (r < 76) begin
			kind = KIND_OFF;
			k = find_open_note();
			if (k >= 0 && $urandom_range(99) < 75)
				key = 7'(k);
		end else if (r < 90) begin
			kind = KIND_DAMPER;
			key = $urandom_range(1) ? DAMPER_DOWN : DAMPER_UP;
		end else if (r < 96) begin
			kind = KIND_DAMPER;
			key = 7'($urandom_range(2, 127));
		end else begin
			kind = KIND_UNUSED;
		end
	endtask

	task automatic test_directed();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		offer_event(KIND_OFF, '0, 7'd0, 7'd127);
		offer_event(KIND_DAMPER, 28'd1, DAMPER_UP, 7'd5);
		offer_event(KIND_ON, DELTA_MAX, 7'd127, 7'd127);
		offer_event(KIND_ON, '0, 7'd0, 7'd0);
		offer_event(KIND_ON, 28'd5, 7'd127, 7'd1);
		offer_event(KIND_OFF, 28'd9, 7'd127, 7'd99);
		offer_event(KIND_OFF, 28'd2, 7'd127, 7'd0);
		offer_event(KIND_OFF, DELTA_MAX, 7'd0, 7'd127);
		offer_event(KIND_ON, 28'h5555555, 7'h55, 7'h2A);
		offer_event(KIND_ON, 28'hAAAAAAA, 7'h2A, 7'h55);
		offer_event(KIND_OFF, 28'd1, 7'h2A, 7'd0);
		offer_event(KIND_OFF, 28'd1, 7'h55, 7'd0);
		offer_event(KIND_DAMPER, 28'd3, DAMPER_DOWN, 7'd0);
		offer_event(KIND_DAMPER, 28'd7, DAMPER_DOWN, 7'd0);
		offer_event(KIND_DAMPER, 28'd11, DAMPER_UP, 7'd0);
		offer_event(KIND_DAMPER, 28'd13, DAMPER_UP, 7'd0);
		// ignored: odd pedal values and the unused kind, time must not move
		offer_event(KIND_DAMPER, DELTA_MAX, 7'd2, 7'd0);
		offer_event(KIND_DAMPER, DELTA_MAX, 7'd127, 7'd127);
		offer_event(KIND_UNUSED, DELTA_MAX, 7'd3, 7'd3);
		offer_event(KIND_OFF, '0, 7'd64, 7'd0);
		stop_sending();
		wait_for_records();
	endtask

	task automatic test_random(input int items, input int idle_pct, input int stall_pct);
		logic [1:0] kind;
		logic [27:0] delta;
		logic [6:0] key;
		logic [6:0] vel;
		int counted;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		counted = 0;
		while (counted < items) begin
			make_event(kind, delta, key, vel);
			offer_event(kind, delta, key, vel);
			if (kind != KIND_UNUSED && !(kind == KIND_DAMPER && key > DAMPER_DOWN))
				counted++;
		end
		stop_sending();
		wait_for_records();
	endtask

	task automatic test_backpressure();
		logic [1:0] kind;
		logic [27:0] delta;
		logic [6:0] key;
		logic [6:0] vel;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_request = 1'b1;
		// every request here makes a record, so the pipe fills behind the hold
		for (int i = 0; i < 30; i++)
			offer_event(KIND_OFF, 28'($urandom_range(3)), 7'($urandom), 7'($urandom));
		while (!hold_done) @(posedge clk);
		for (int i = 0; i < 20; i++) begin
			make_event(kind, delta, key, vel);
			offer_event(kind, delta, key, vel);
		end
		stop_sending();
		wait_for_records();
		receiver_stall_pct = 26;
		for (int i = 0; i < 20; i++) begin
			make_event(kind, delta, key, vel);
			offer_event(kind, delta, key, vel);
		end
		stop_sending();
		wait_for_records();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = KIND_ON;
		delta_ticks = '0;
		value_one = '0;
		velocity = '0;
		clock_now = '0;
		pedal_start = '0;
		pedal_open = 1'b0;
		for (int i = 0; i < PITCHES; i++)
			note_open[i] = 1'b0;
		fail_count = 0;
		cycle_count = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_request = 1'b0;
		hold_done = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random(250, 0, 0);
		test_random(250, 72, 0);
		test_random(250, 0, 72);
		test_random(250, 26, 26);
		test_backpressure();

		wait_for_records();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("midi_event_to_note_duration_unit verification clean");
		else
			$display("midi_event_to_note_duration_unit verification failed");
		$finish;
	end

endmodule
